// ===== src/s2a_pkg.sv =====
// ----------------------------------------------------------------------------
// s2a_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package s2a_pkg;

  localparam int WordW     = 32;
  localparam int NumDigits = 10;
  localparam int DigW      = 4;
  localparam int BitCntW   = $clog2(WordW);
  localparam int DigIdxW   = $clog2(NumDigits);

  localparam logic [7:0] CodeZero  = 8'd48;
  localparam logic [7:0] CodeMinus = 8'd45;

  localparam logic [DigW-1:0] AdjThresh = 4'd5;
  localparam logic [DigW-1:0] AdjAdd    = 4'd3;

  typedef logic [NumDigits-1:0][DigW-1:0] bcd_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic seek;
    logic emit_sign;
    logic emit_digit;
  } s2a_cmd_t;

  typedef struct packed {
    logic neg;
    logic conv_done;
    logic digit_last;
  } s2a_sts_t;

endpackage

// ===== src/s2a_ctrl.sv =====
// ----------------------------------------------------------------------------
// s2a_ctrl
// Sequencer: load, 32 conversion steps, digit seek, optional sign, digits.
// ----------------------------------------------------------------------------
module s2a_ctrl import s2a_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  s2a_sts_t  sts,
  output s2a_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SEEK,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t state;

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == ST_IDLE) && start;
    cmd.conv       = (state == ST_CONV);
    cmd.seek       = (state == ST_SEEK);
    cmd.emit_sign  = (state == ST_SIGN);
    cmd.emit_digit = (state == ST_DIGIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CONV;
            busy  <= 1'b1;
          end
        end
        ST_CONV: begin
          if (sts.conv_done) state <= ST_SEEK;
        end
        ST_SEEK: begin
          state <= sts.neg ? ST_SIGN : ST_DIGIT;
        end
        ST_SIGN: begin
          state <= ST_DIGIT;
        end
        ST_DIGIT: begin
          if (sts.digit_last) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== src/s2a_dp.sv =====
// ----------------------------------------------------------------------------
// s2a_dp
// Datapath: magnitude, shift-add-3 BCD conversion, digit pointer, output
// register.
// ----------------------------------------------------------------------------
module s2a_dp import s2a_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  s2a_cmd_t         cmd,
  input  logic [WordW-1:0] value,
  output s2a_sts_t         sts,
  output logic [7:0]       char_code,
  output logic             last,
  output logic             strobe
);

  logic [WordW-1:0]            mag;
  bcd_t                        bcd;
  bcd_t                        bcd_adj;
  logic [NumDigits*DigW-1:0]   bcd_flat;
  logic                        neg;
  logic [BitCntW-1:0]          bit_cnt;
  logic [DigIdxW-1:0]          dig_idx;
  logic [DigIdxW-1:0]          top_idx;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i] = (bcd[i] >= AdjThresh) ? bcd[i] + AdjAdd : bcd[i];
    end
  end

  assign bcd_flat = bcd_adj;

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[i] != '0) top_idx = DigIdxW'(i);
    end
  end

  assign sts.neg        = neg;
  assign sts.conv_done  = (bit_cnt == BitCntW'(WordW - 1));
  assign sts.digit_last = (dig_idx == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= value[WordW-1];
      mag     <= value[WordW-1] ? (~value + WordW'(1)) : value;
      bcd     <= '0;
      bit_cnt <= '0;
    end else if (cmd.conv) begin
      bcd     <= {bcd_flat[NumDigits*DigW-2:0], mag[WordW-1]};
      mag     <= {mag[WordW-2:0], 1'b0};
      bit_cnt <= bit_cnt + BitCntW'(1);
    end
    if (cmd.seek) begin
      dig_idx <= top_idx;
    end else if (cmd.emit_digit) begin
      dig_idx <= dig_idx - DigIdxW'(1);
    end
    if (cmd.emit_sign) begin
      char_code <= CodeMinus;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= CodeZero + {4'd0, bcd[dig_idx]};
      last      <= (dig_idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign | cmd.emit_digit;
    end
  end

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Renders a 32-bit two's complement integer as decimal ASCII text, most
// significant character first, one character per strobe.
// ----------------------------------------------------------------------------
//  channel  | handshake        | ports
//  ---------+------------------+------------------------------
//  input    | start & !busy    | value[31:0]
//  result   | strobe           | char_code[7:0], last
//
//  While an item is in flight, busy stays high through 32 shift-add-3 steps
//  in the BCD converter, a step to locate the leading digit, a step for the
//  minus sign on negative values, and one step for each of 1 to 10 digits.
//  Each character appears in the cycle after its emit cycle; the next start may
//  be taken in the cycle that shows the final character.
//  Synchronous active-high reset returns the sequencer to idle.
//  The receiver cannot stall; characters are never held back.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii import s2a_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [WordW-1:0] value,
  output logic             strobe,
  output logic [7:0]       char_code,
  output logic             last
);

  s2a_cmd_t cmd;
  s2a_sts_t sts;

  s2a_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  s2a_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .sts       (sts),
    .char_code (char_code),
    .last      (last),
    .strobe    (strobe)
  );

endmodule

// ===== src/s2a_chk.sv =====
// ----------------------------------------------------------------------------
// s2a_chk
// Port-level checks for the decimal text block, bound to the top level.
// ----------------------------------------------------------------------------
module s2a_chk import s2a_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [7:0] char_code,
  input logic       last
);

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (char_code == CodeMinus) ||
               ((char_code >= CodeZero) && (char_code <= CodeZero + 8'd9)))
    else $error("character code out of range");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (char_code == CodeMinus)) |-> !last)
    else $error("minus sign flagged as last");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy && !strobe)
    else $error("accept not followed by busy conversion");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("beat follows last character");

  a_strobe_while_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("mid-run beat while idle");

endmodule

bind signed_int_to_decimal_ascii s2a_chk u_s2a_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .char_code (char_code),
  .last      (last)
);
